>>> design/csdc_pkg.sv
// ----------------------------------------------------------------------------
// csdc_pkg
// Shared types and constants for the call-stack signature dedup counter.
// ----------------------------------------------------------------------------
package csdc_pkg;

	localparam int unsigned TableEntriesDef = 64;
	localparam int unsigned MaxFramesDef    = 255;
	localparam logic [63:0] FnvBasis        = 64'hcbf29ce484222325;
	localparam logic [63:0] FnvPrime        = 64'h00000100000001b3;
	localparam logic [15:0] DefaultLimit    = 16'd32;

	typedef enum logic [2:0] {
		OP_FRAME  = 3'd0,
		OP_EMPTY  = 3'd1,
		OP_ARM    = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_DISARM = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_FRAME     = 4'd0,
		ST_NEW       = 4'd1,
		ST_MATCH     = 4'd2,
		ST_FULL      = 4'd3,
		ST_IGNORED   = 4'd4,
		ST_EMPTY     = 4'd5,
		ST_ARMED     = 4'd6,
		ST_REFUSED   = 4'd7,
		ST_CLEARED   = 4'd8,
		ST_DISARMED  = 4'd9,
		ST_READ      = 4'd10,
		ST_TOO_DEEP  = 4'd11,
		ST_BAD_INDEX = 4'd12
	} status_t;

	localparam logic [0:0] RegArmedAddr  = 1'd0;
	localparam logic [0:0] RegMaxSamples = 1'd1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] breakpoint_address;
		logic [63:0] frame_site;
		logic [63:0] frame_caller;
		logic [63:0] frame_target;
		logic        last_frame;
		logic [5:0]  read_index;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        is_armed;
		logic        auto_disarmed;
		logic [31:0] hit_total;
		logic [6:0]  distinct_count;
		logic [5:0]  entry_slot;
		logic [31:0] entry_hits;
		logic [31:0] entry_first_seq;
		logic [7:0]  entry_depth;
		logic [63:0] entry_hash;
	} result_t;

	// table entry layout: hash, depth, hits, first sequence
	localparam int unsigned EntryW = 64 + 8 + 32 + 32;

endpackage

>>> design/csdc_ram.sv
// ----------------------------------------------------------------------------
// csdc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module csdc_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> design/call_stack_signature_dedup_counter_unit.sv
// ----------------------------------------------------------------------------
// call_stack_signature_dedup_counter_unit
// FNV-1a 64 call-stack hashing with a dedup table of stack signatures.
// ----------------------------------------------------------------------------
// Sequence: a folded frame takes 24 byte steps of one shift-add unit;
//   a last frame adds a scan of the stored entries, then a match update, a new entry or full.
//   Control items finish from idle; reads pass a wait state. One item at a time (busy).
// The result strobe is high one cycle; the receiver cannot stall.
// Reset clears all control state at once; the table holds no reset value and
//   only entries below the stored count are ever read.
module call_stack_signature_dedup_counter_unit #(
	parameter int unsigned TableEntries = csdc_pkg::TableEntriesDef,
	parameter int unsigned MaxFrames    = csdc_pkg::MaxFramesDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  csdc_pkg::item_t   item,
	output logic           done,
	output csdc_pkg::result_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [63:0]    pwdata,
	output logic [63:0]    prdata,
	output logic           pready
);
	import csdc_pkg::*;

	localparam int unsigned AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int unsigned CW = $clog2(TableEntries + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_FOLD, S_SCAN_RD, S_SCAN_CMP, S_WRITE, S_READ_WAIT, S_READ_OUT
	} state_t;

	state_t       state_q;
	item_t        item_q;
	logic [63:0]  armed_addr_q;
	logic [15:0]  max_samples_q;
	logic [63:0]  hash_q;
	logic [8:0]   frames_q;
	logic         armed_q;
	logic [31:0]  hits_q;
	logic [31:0]  seq_q;
	logic [CW-1:0] stored_q;
	logic [4:0]   byte_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] scan_q;

	// ram port
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [EntryW-1:0] ram_wdata, ram_rdata;

	csdc_ram #(.Width(EntryW), .Depth(TableEntries)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// APB
	assign pready = 1'b1;
	always_comb begin
		case (paddr[3:3] == 1'b0 ? RegArmedAddr : RegMaxSamples)
			RegArmedAddr: prdata = armed_addr_q;
			default:      prdata = {48'd0, max_samples_q};
		endcase
	end

	// byte fold: one xor and one multiply by the prime per step
	logic [191:0] words;
	logic [7:0]   cur_byte;
	logic [63:0]  fold_x;
	logic [63:0]  fold_next;
	assign words    = {item_q.frame_target, item_q.frame_caller, item_q.frame_site};
	assign cur_byte = words[{byte_q, 3'b000} +: 8];
	assign fold_x   = hash_q ^ {56'd0, cur_byte};
	// prime is 2^40 + 0x1b3: shift-and-add, modulo 2^64
	assign fold_next = (fold_x << 40) + (fold_x << 8) + (fold_x << 7) + (fold_x << 5)
		+ (fold_x << 4) + (fold_x << 1) + fold_x;

	logic [63:0]  ram_hash;
	logic [7:0]   ram_depth;
	logic [31:0]  ram_hits, ram_seq;
	assign {ram_hash, ram_depth, ram_hits, ram_seq} = ram_rdata;

	logic [15:0] limit;
	assign limit = (max_samples_q == 16'd0) ? DefaultLimit : max_samples_q;
	logic [31:0] hits_inc;
	assign hits_inc = (hits_q == 32'hffffffff) ? hits_q : hits_q + 32'd1;
	logic match_bp;
	assign match_bp = armed_q && (item.breakpoint_address == armed_addr_q);
	logic entry_eq;
	assign entry_eq = (ram_depth == frames_q[7:0]) && (ram_hash == hash_q);

	assign busy = (state_q != S_IDLE);
	assign ram_addr = (state_q == S_READ_WAIT || state_q == S_READ_OUT) ? idx_q
		: ((state_q == S_WRITE) ? idx_q : scan_q[AW-1:0]);
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {hash_q, frames_q[7:0], 32'd1, seq_q + 32'd1};
		if (state_q == S_WRITE) begin
			ram_we = 1'b1;
		end else if (state_q == S_SCAN_CMP && scan_q < stored_q && entry_eq) begin
			ram_we    = 1'b1;
			ram_wdata = {ram_hash, ram_depth,
				(ram_hits == 32'hffffffff) ? ram_hits : ram_hits + 32'd1, ram_seq};
		end
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			armed_addr_q  <= '0;
			max_samples_q <= '0;
			hash_q        <= FnvBasis;
			frames_q      <= '0;
			armed_q       <= 1'b0;
			hits_q        <= '0;
			seq_q         <= '0;
			stored_q      <= '0;
			byte_q        <= '0;
			idx_q         <= '0;
			scan_q        <= '0;
			done          <= 1'b0;
			result        <= '0;
			item_q        <= '0;
		end else begin
			done <= 1'b0;
			if (psel && penable && pwrite) begin
				if (paddr[3:3] == RegArmedAddr) armed_addr_q <= pwdata;
				else max_samples_q <= pwdata[15:0];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q <= item;
						result <= '0;
						result.hit_total <= hits_q;
						result.distinct_count <= 7'(stored_q);
						result.is_armed <= armed_q;
						result.status <= ST_IGNORED;
						case (item.opcode)
							OP_FRAME: begin
								if (match_bp) begin
									if (frames_q < 9'(MaxFrames)) begin
										byte_q  <= '0;
										state_q <= S_FOLD;
									end else if (item.last_frame) begin
										hash_q   <= FnvBasis;
										frames_q <= '0;
										result.status <= ST_TOO_DEEP;
										if (hits_q >= {16'd0, limit}) begin
											armed_q <= 1'b0;
											result.is_armed <= 1'b0;
											result.auto_disarmed <= 1'b1;
										end
										done <= 1'b1;
									end else begin
										frames_q <= 9'(MaxFrames) + 9'd1;
										result.status <= ST_TOO_DEEP;
										done <= 1'b1;
									end
								end else begin
									done <= 1'b1;
								end
							end
							OP_EMPTY: begin
								if (match_bp) begin
									hash_q   <= FnvBasis;
									frames_q <= '0;
									result.status <= ST_EMPTY;
									if (hits_q >= {16'd0, limit}) begin
										armed_q <= 1'b0;
										result.is_armed <= 1'b0;
										result.auto_disarmed <= 1'b1;
									end
								end
								done <= 1'b1;
							end
							OP_ARM: begin
								if (armed_addr_q == 64'd0) begin
									result.status <= ST_REFUSED;
								end else begin
									stored_q <= '0; hits_q <= '0; seq_q <= '0;
									hash_q <= FnvBasis; frames_q <= '0;
									armed_q <= 1'b1;
									result.status <= ST_ARMED;
									result.is_armed <= 1'b1;
									result.hit_total <= '0;
									result.distinct_count <= '0;
								end
								done <= 1'b1;
							end
							OP_CLEAR: begin
								stored_q <= '0; hits_q <= '0; seq_q <= '0;
								hash_q <= FnvBasis; frames_q <= '0;
								result.status <= ST_CLEARED;
								result.hit_total <= '0;
								result.distinct_count <= '0;
								done <= 1'b1;
							end
							OP_DISARM: begin
								armed_q <= 1'b0;
								hash_q <= FnvBasis; frames_q <= '0;
								result.status <= ST_DISARMED;
								result.is_armed <= 1'b0;
								done <= 1'b1;
							end
							OP_READ: begin
								if ({1'b0, item.read_index} < 7'(stored_q)
										&& 32'(item.read_index) < TableEntries) begin
									idx_q   <= AW'(item.read_index);
									state_q <= S_READ_WAIT;
								end else begin
									result.status <= ST_BAD_INDEX;
									done <= 1'b1;
								end
							end
							default: done <= 1'b1;
						endcase
					end
				end
				S_FOLD: begin
					hash_q <= fold_next;
					byte_q <= byte_q + 5'd1;
					if (byte_q == 5'd23) begin
						frames_q <= frames_q + 9'd1;
						if (item_q.last_frame) begin
							hits_q  <= hits_inc;
							scan_q  <= '0;
							state_q <= S_SCAN_RD;
						end else begin
							result.status <= ST_FRAME;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN_RD: begin
					// address presented; data valid next cycle
					if (scan_q < stored_q) begin
						state_q <= S_SCAN_CMP;
					end else if (stored_q < CW'(TableEntries)) begin
						idx_q   <= AW'(stored_q);
						state_q <= S_WRITE;
					end else begin
						result.status <= ST_FULL;
						result.hit_total <= hits_q;
						hash_q <= FnvBasis; frames_q <= '0;
						if (hits_q >= {16'd0, limit}) begin
							armed_q <= 1'b0;
							result.auto_disarmed <= 1'b1;
						end
						result.is_armed <= armed_q && !(hits_q >= {16'd0, limit});
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN_CMP: begin
					if (entry_eq) begin
						result.status     <= ST_MATCH;
						result.entry_slot <= 6'(scan_q);
						result.entry_hits <= (ram_hits == 32'hffffffff) ? ram_hits
							: ram_hits + 32'd1;
						result.entry_first_seq <= ram_seq;
						result.entry_depth <= ram_depth;
						result.entry_hash  <= ram_hash;
						result.hit_total   <= hits_q;
						result.distinct_count <= 7'(stored_q);
						hash_q <= FnvBasis; frames_q <= '0;
						if (hits_q >= {16'd0, limit}) begin
							armed_q <= 1'b0;
							result.auto_disarmed <= 1'b1;
						end
						result.is_armed <= armed_q && !(hits_q >= {16'd0, limit});
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_q  <= scan_q + CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_WRITE: begin
					seq_q    <= seq_q + 32'd1;
					stored_q <= stored_q + CW'(1);
					result.status     <= ST_NEW;
					result.entry_slot <= 6'(idx_q);
					result.entry_hits <= 32'd1;
					result.entry_first_seq <= seq_q + 32'd1;
					result.entry_depth <= frames_q[7:0];
					result.entry_hash  <= hash_q;
					result.hit_total   <= hits_q;
					result.distinct_count <= 7'(stored_q + CW'(1));
					hash_q <= FnvBasis; frames_q <= '0;
					if (hits_q >= {16'd0, limit}) begin
						armed_q <= 1'b0;
						result.auto_disarmed <= 1'b1;
					end
					result.is_armed <= armed_q && !(hits_q >= {16'd0, limit});
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_READ_WAIT: state_q <= S_READ_OUT;
				S_READ_OUT: begin
					result.status     <= ST_READ;
					result.entry_slot <= 6'(idx_q);
					result.entry_hits <= ram_hits;
					result.entry_first_seq <= ram_seq;
					result.entry_depth <= ram_depth;
					result.entry_hash  <= ram_hash;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result only follows work: two strobes back to back need a start with the first
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done || $past(start)) else $error("double result strobe");
	// stored count never exceeds the table
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(TableEntries)) else $error("stored count overflow");
	// frames counter never passes the overflow mark
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q <= 9'(MaxFrames) + 9'd1) else $error("frame count overflow");
	// accepting an item makes the block busy or gives a result next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("item lost");
`endif
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the call-stack signature dedup counter.
// Streams breakpoint hits, control commands and entry reads through the
// start/busy port, predicts every result with an independent FNV-1a table
// model, and rewrites the two registers over APB between phases.
// ----------------------------------------------------------------------------
module tb;
	import csdc_pkg::*;

	localparam int NEntries   = 64;
	localparam int NFrames    = 255;
	localparam int CycleLimit = 2000000;
	localparam logic [3:0] AddrArmed = 4'(8 * RegArmedAddr);
	localparam logic [3:0] AddrMax   = 4'(8 * RegMaxSamples);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, pready;
	item_t item = '0;
	result_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0, prdata;

	call_stack_signature_dedup_counter_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0] cfg_addr = '0;
	logic [15:0] cfg_max = '0;
	logic [63:0] sig_hash = FnvBasis;
	int unsigned frame_cnt = 0;
	logic armed = 1'b0;
	logic [31:0] hit_cnt = '0, seq_cnt = '0;
	int unsigned n_stored = 0;
	logic [63:0] tbl_hash [NEntries];
	logic [7:0]  tbl_depth [NEntries];
	logic [31:0] tbl_hits [NEntries];
	logic [31:0] tbl_seq [NEntries];

	item_t pending_items [$];
	result_t expected_results [$];
	int unsigned fail_cnt = 0;
	logic taken = 1'b0;
	int unsigned burst_left = 0, gap_left = 0;

	// random stack pool for repeat hits
	logic [63:0] pool_w [8][4][3];
	int unsigned pool_d [8];

	function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [63:0] w);
		for (int i = 0; i < 8; i++) begin
			h = (h ^ {56'd0, w[8*i +: 8]}) * FnvPrime;
		end
		return h;
	endfunction

	function automatic logic limit_reached();
		logic [31:0] lim;
		lim = (cfg_max == 0) ? 32'(DefaultLimit) : 32'(cfg_max);
		if (hit_cnt >= lim) begin
			armed = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void load_entry(ref result_t r, input int unsigned s);
		r.entry_slot      = 6'(s);
		r.entry_hits      = tbl_hits[s];
		r.entry_first_seq = tbl_seq[s];
		r.entry_depth     = tbl_depth[s];
		r.entry_hash      = tbl_hash[s];
	endfunction

	function automatic result_t dedup_step(item_t it);
		result_t r;
		status_t st;
		logic bp_ok, autod;
		int unsigned j;
		r = '0;
		st = ST_IGNORED;
		autod = 1'b0;
		bp_ok = armed && it.breakpoint_address == cfg_addr;
		case (it.opcode)
			OP_FRAME: if (bp_ok) begin
				if (frame_cnt < NFrames) begin
					sig_hash = fnv_fold(sig_hash, it.frame_site);
					sig_hash = fnv_fold(sig_hash, it.frame_caller);
					sig_hash = fnv_fold(sig_hash, it.frame_target);
					frame_cnt++;
					st = ST_FRAME;
				end else begin
					frame_cnt = NFrames + 1;
					st = ST_TOO_DEEP;
				end
				if (it.last_frame && st == ST_TOO_DEEP) begin
					sig_hash = FnvBasis;
					frame_cnt = 0;
					autod = limit_reached();
				end else if (it.last_frame) begin
					if (hit_cnt != '1) hit_cnt++;
					for (j = 0; j < n_stored; j++)
						if (tbl_depth[j] == frame_cnt && tbl_hash[j] == sig_hash) break;
					if (j < n_stored) begin
						if (tbl_hits[j] != '1) tbl_hits[j]++;
						st = ST_MATCH;
						load_entry(r, j);
					end else if (n_stored < NEntries) begin
						tbl_hash[n_stored] = sig_hash;
						tbl_depth[n_stored] = 8'(frame_cnt);
						tbl_hits[n_stored] = 32'd1;
						seq_cnt++;
						tbl_seq[n_stored] = seq_cnt;
						load_entry(r, n_stored);
						n_stored++;
						st = ST_NEW;
					end else begin
						st = ST_FULL;
					end
					sig_hash = FnvBasis;
					frame_cnt = 0;
					autod = limit_reached();
				end
			end
			OP_EMPTY: if (bp_ok) begin
				st = ST_EMPTY;
				sig_hash = FnvBasis;
				frame_cnt = 0;
				autod = limit_reached();
			end
			OP_ARM: if (cfg_addr == 0) begin
				st = ST_REFUSED;
			end else begin
				n_stored = 0; hit_cnt = '0; seq_cnt = '0;
				sig_hash = FnvBasis; frame_cnt = 0;
				armed = 1'b1;
				st = ST_ARMED;
			end
			OP_CLEAR: begin
				n_stored = 0; hit_cnt = '0; seq_cnt = '0;
				sig_hash = FnvBasis; frame_cnt = 0;
				st = ST_CLEARED;
			end
			OP_DISARM: begin
				armed = 1'b0;
				sig_hash = FnvBasis; frame_cnt = 0;
				st = ST_DISARMED;
			end
			OP_READ: if (32'(it.read_index) < n_stored) begin
				st = ST_READ;
				load_entry(r, 32'(it.read_index));
			end else begin
				st = ST_BAD_INDEX;
			end
			default: ;
		endcase
		r.status = st;
		r.is_armed = armed;
		r.auto_disarmed = autod;
		r.hit_total = hit_cnt;
		r.distinct_count = 7'(n_stored);
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	// monitor: predict on each accepted command, check each result transfer
	always @(posedge clk) begin
		result_t e;
		taken <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			expected_results.insert(expected_results.size(), dedup_step(item));
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no expectation pending");
				fail_cnt++;
			end else begin
				e = expected_results.pop_front();
				check_field("status", 64'(e.status), 64'(result.status));
				check_field("is_armed", 64'(e.is_armed), 64'(result.is_armed));
				check_field("auto_disarmed", 64'(e.auto_disarmed),
					64'(result.auto_disarmed));
				check_field("hit_total", 64'(e.hit_total), 64'(result.hit_total));
				check_field("distinct_count", 64'(e.distinct_count),
					64'(result.distinct_count));
				check_field("entry_slot", 64'(e.entry_slot), 64'(result.entry_slot));
				check_field("entry_hits", 64'(e.entry_hits), 64'(result.entry_hits));
				check_field("entry_first_seq", 64'(e.entry_first_seq),
					64'(result.entry_first_seq));
				check_field("entry_depth", 64'(e.entry_depth), 64'(result.entry_depth));
				check_field("entry_hash", e.entry_hash, result.entry_hash);
			end
		end
	end

	// driver: bursts of commands separated by random gaps
	always @(negedge clk) begin
		if (!arst_n || (start && !taken)) begin
			// hold the current command
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (pending_items.size() > 0) begin
			item <= pending_items.pop_front();
			start <= 1'b1;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// watchdog
	int unsigned cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic void queue_cmd(op_t op);
		item_t it;
		it = '0;
		it.opcode = op;
		it.breakpoint_address = rand64();
		it.frame_site = rand64();
		it.frame_caller = rand64();
		it.frame_target = rand64();
		it.last_frame = 1'($urandom());
		it.read_index = 6'($urandom());
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void queue_read(int unsigned idx);
		item_t it;
		it = '0;
		it.opcode = OP_READ;
		it.read_index = 6'(idx);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void queue_empty_hit(logic [63:0] bp);
		item_t it;
		it = '0;
		it.opcode = OP_EMPTY;
		it.breakpoint_address = bp;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// one hit: depth frames, from the pool when p < 8, else random words
	function automatic void queue_hit(logic [63:0] bp, int p, int unsigned depth);
		item_t it;
		for (int unsigned f = 0; f < depth; f++) begin
			it = '0;
			it.opcode = OP_FRAME;
			it.breakpoint_address = bp;
			it.last_frame = (f == depth - 1);
			if (p < 8) begin
				it.frame_site = pool_w[p][f][0];
				it.frame_caller = pool_w[p][f][1];
				it.frame_target = pool_w[p][f][2];
			end else begin
				it.frame_site = rand64();
				it.frame_caller = rand64();
				it.frame_target = rand64();
			end
			pending_items.insert(pending_items.size(), it);
		end
	endfunction

	task automatic wait_idle();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [3:0] a, logic [63:0] d);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (a == AddrArmed) cfg_addr = d;
		else cfg_max = d[15:0];
	endtask

	initial begin
		logic [63:0] addr_set [5];
		logic [15:0] max_set [5];
		logic [63:0] bp;
		int unsigned r;
		for (int p = 0; p < 8; p++) begin
			pool_d[p] = $urandom_range(1, 4);
			for (int f = 0; f < 4; f++)
				for (int k = 0; k < 3; k++) pool_w[p][f][k] = rand64();
		end
		pool_w[0][0][0] = '0; pool_w[0][0][1] = '0; pool_w[0][0][2] = '0;
		pool_w[1][0][0] = '1; pool_w[1][0][1] = '1; pool_w[1][0][2] = '1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// out of reset: nothing armed, address zero
		queue_cmd(OP_ARM);
		queue_hit(rand64(), 8, 1);
		queue_empty_hit('0);
		queue_read(0);
		queue_cmd(op_t'(3'd6));
		queue_cmd(op_t'(3'd7));
		queue_cmd(OP_DISARM);
		queue_cmd(OP_CLEAR);
		wait_idle();

		// basic arm, new entry, match, reads
		reg_write(AddrArmed, 64'hffff_ffff_ffff_ffff);
		reg_write(AddrMax, 64'd0);
		bp = cfg_addr;
		queue_cmd(OP_ARM);
		queue_empty_hit(64'd5);
		queue_empty_hit(bp);
		queue_hit(bp, 0, 1);
		queue_hit(bp, 0, 1);
		queue_hit(bp, 1, 1);
		queue_read(0);
		queue_read(1);
		queue_read(63);
		queue_cmd(OP_DISARM);
		queue_read(0);
		queue_cmd(OP_CLEAR);
		queue_read(0);
		wait_idle();

		// table fill and too-deep stack
		reg_write(AddrMax, 64'hffff);
		reg_write(AddrArmed, 64'd1);
		bp = 64'd1;
		queue_cmd(OP_ARM);
		queue_hit(bp, 8, 257);
		for (int i = 0; i < 66; i++) queue_hit(bp, 8, 1);
		queue_hit(bp, 2, pool_d[2]);
		queue_read(63);
		queue_read(0);
		wait_idle();

		// random phases over several register settings
		addr_set = '{64'd1, 64'hffff_ffff_ffff_ffff, rand64() | 64'd1, rand64() | 64'd2,
			rand64() | 64'h8000_0000_0000_0000};
		max_set = '{16'd1, 16'd3, 16'd0, 16'hffff, 16'($urandom_range(2, 40))};
		for (int ph = 0; ph < 5; ph++) begin
			reg_write(AddrArmed, addr_set[ph]);
			reg_write(AddrMax, {48'd0, max_set[ph]});
			bp = cfg_addr;
			queue_cmd(OP_ARM);
			for (int n = 0; n < 42; n++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					if ($urandom_range(0, 2) == 0) queue_hit(bp, 8, $urandom_range(1, 3));
					else queue_hit(($urandom_range(0, 9) == 0) ? rand64() : bp,
						$urandom_range(0, 7), pool_d[$urandom_range(0, 7)]);
				end else if (r < 68) queue_empty_hit(($urandom_range(0, 3) == 0) ? rand64() : bp);
				else if (r < 78) queue_read($urandom_range(0, 63));
				else if (r < 88) queue_cmd(OP_ARM);
				else if (r < 91) queue_cmd(OP_CLEAR);
				else if (r < 94) queue_cmd(OP_DISARM);
				else queue_cmd(op_t'(3'($urandom_range(0, 7))));
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
design/csdc_pkg.sv
design/csdc_ram.sv
design/call_stack_signature_dedup_counter_unit.sv
tb/sv/tb.sv
